### rtl/core/binary_arith_encoder_order0_assert.svh
// ----------------------------------------------------------------------------
// binary_arith_encoder_order0_assert.svh
// Assertion macros used by the port-level checker of the arithmetic encoder.
// ----------------------------------------------------------------------------
`ifndef BINARY_ARITH_ENCODER_ORDER0_ASSERT_SVH
`define BINARY_ARITH_ENCODER_ORDER0_ASSERT_SVH

// Checks that cons holds in the same cycle as ante.
`define BAE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante.
`define BAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bae_pkg.sv
// ----------------------------------------------------------------------------
// bae_pkg
// Widths, constants, types and helper functions of the arithmetic encoder.
// ----------------------------------------------------------------------------
package bae_pkg;

  localparam int PROB_BITS    = 12;
  localparam int RANGE_BITS   = 64;
  localparam int BYTE_BITS    = 8;
  localparam int CTX_BITS     = 8;
  localparam int NODES        = 1 << CTX_BITS;
  localparam int SHIFT_BITS   = 4;
  localparam int BIT_IDX_BITS = 3;
  localparam int SPAN_Q_BITS  = RANGE_BITS - PROB_BITS;
  localparam int FLUSH_BYTES  = RANGE_BITS / BYTE_BITS;
  localparam int FCNT_BITS    = $clog2(FLUSH_BYTES);

  typedef logic [PROB_BITS-1:0]  prob_t;
  typedef logic [RANGE_BITS-1:0] range_t;
  typedef logic [BYTE_BITS-1:0]  byte_t;
  typedef logic [CTX_BITS-1:0]   ctx_t;
  typedef logic [SHIFT_BITS-1:0] shift_t;

  localparam prob_t                PROB_HALF  = PROB_BITS'(1) << (PROB_BITS - 1);
  localparam logic [PROB_BITS:0]   PROB_SCALE = (PROB_BITS + 1)'(1) << PROB_BITS;
  localparam range_t               RANGE_ONES = '1;
  localparam byte_t                BYTE_ONES  = '1;
  localparam ctx_t                 CTX_ROOT   = CTX_BITS'(1);
  localparam logic [BIT_IDX_BITS-1:0] BIT_MSB = '1;
  localparam logic [FCNT_BITS-1:0] FLUSH_LAST = FCNT_BITS'(FLUSH_BYTES - 1);

  localparam shift_t SHIFT_MIN   = SHIFT_BITS'(1);
  localparam shift_t SHIFT_MAX   = SHIFT_BITS'(8);
  localparam shift_t SHIFT_RESET = SHIFT_BITS'(5);

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // Controls of the probability store.
  typedef struct packed {
    logic  rd_en;
    ctx_t  rd_addr;
    logic  wr_en;
    ctx_t  wr_addr;
    prob_t wr_data;
    logic  clear_all;
  } prob_ctl_t;

  // Controls of the range unit.
  typedef struct packed {
    logic mul_en;
    logic upd_en;
    logic bit_val;
    logic shift_en;
    logic clear;
  } coder_ctl_t;

  // Zero acts as one, values above the maximum saturate.
  function automatic shift_t eff_shift(shift_t s);
    shift_t r;
    if (s == '0) begin
      r = SHIFT_MIN;
    end else if (s > SHIFT_MAX) begin
      r = SHIFT_MAX;
    end else begin
      r = s;
    end
    return r;
  endfunction

  // Moves the probability toward the coded bit's end of the scale.
  function automatic prob_t prob_adapt(prob_t p, logic bit_val, shift_t sh);
    logic [PROB_BITS:0] p_ext;
    logic [PROB_BITS:0] p_new;
    p_ext = {1'b0, p};
    if (bit_val) begin
      p_new = p_ext + ((PROB_SCALE - p_ext) >> sh);
    end else begin
      p_new = p_ext - (p_ext >> sh);
    end
    return p_new[PROB_BITS-1:0];
  endfunction

endpackage

### rtl/core/bae_prob_ram.sv
// ----------------------------------------------------------------------------
// bae_prob_ram
// Probability store: one synchronous memory with registered read data and a
// row of valid bits, so that an unwritten node reads as one half.
// ----------------------------------------------------------------------------
module bae_prob_ram (
  input  logic              clk,
  input  logic              rst,
  input  bae_pkg::prob_ctl_t ctl,
  output bae_pkg::prob_t    rd_prob
);

  bae_pkg::prob_t             mem [bae_pkg::NODES];
  logic [bae_pkg::NODES-1:0]  valid;
  bae_pkg::prob_t             rd_data;
  logic                       rd_hit;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
  end

  // Read data is registered; a write to the same node in the same cycle is
  // forwarded.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      if (ctl.wr_en && (ctl.wr_addr == ctl.rd_addr)) begin
        rd_data <= ctl.wr_data;
        rd_hit  <= 1'b1;
      end else begin
        rd_data <= mem[ctl.rd_addr];
        rd_hit  <= valid[ctl.rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear_all) begin
      valid <= '0;
    end else if (ctl.wr_en) begin
      valid[ctl.wr_addr] <= 1'b1;
    end
  end

  assign rd_prob = rd_hit ? rd_data : bae_pkg::PROB_HALF;

endmodule

### rtl/core/bae_range.sv
// ----------------------------------------------------------------------------
// bae_range
// Range unit: holds low and high, splits the range with one registered
// multiply, narrows it and shifts out settled top bytes.
// ----------------------------------------------------------------------------
module bae_range (
  input  logic                clk,
  input  logic                rst,
  input  bae_pkg::coder_ctl_t ctl,
  input  bae_pkg::prob_t      prob,
  output bae_pkg::byte_t      top_byte,
  output logic                top_match
);

  bae_pkg::range_t low;
  bae_pkg::range_t high;
  bae_pkg::range_t prod;
  bae_pkg::range_t span;
  bae_pkg::range_t mid;
  logic [bae_pkg::SPAN_Q_BITS+bae_pkg::PROB_BITS-1:0] mul_full;

  always_comb begin
    span     = high - low;
    mul_full = span[bae_pkg::RANGE_BITS-1:bae_pkg::PROB_BITS] * prob;
    mid      = low + prod;
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= mul_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      low  <= '0;
      high <= bae_pkg::RANGE_ONES;
    end else if (ctl.upd_en) begin
      if (ctl.bit_val) begin
        high <= mid;
      end else begin
        low <= mid + bae_pkg::RANGE_BITS'(1);
      end
    end else if (ctl.shift_en) begin
      low  <= {low[bae_pkg::RANGE_BITS-bae_pkg::BYTE_BITS-1:0], bae_pkg::BYTE_BITS'(0)};
      high <= {high[bae_pkg::RANGE_BITS-bae_pkg::BYTE_BITS-1:0], bae_pkg::BYTE_ONES};
    end
  end

  assign top_byte  = low[bae_pkg::RANGE_BITS-1 -: bae_pkg::BYTE_BITS];
  assign top_match = (top_byte == high[bae_pkg::RANGE_BITS-1 -: bae_pkg::BYTE_BITS]);

endmodule

### rtl/core/binary_arith_encoder_order0.sv
// ----------------------------------------------------------------------------
// binary_arith_encoder_order0
// Adaptive binary arithmetic encoder with an order-0 bitwise byte model.
// ----------------------------------------------------------------------------
// An encode item (op low) codes one byte, most significant bit first, as
// eight binary decisions; each decision reads a 12-bit probability from a
// 256-entry tree of nodes, splits the 64-bit range with one multiply, and
// writes the adapted probability back. One item is worked on at a time: an
// encode item fetches the root node, runs the bit loop, shifting out each
// settled byte, and ends in a closing state. The rate is set by the bit loop,
// where each decision runs a multiply stage followed by an add-and-narrow
// stage around the probability memory. A flush item (op high) delivers the
// eight bytes of low, most significant first, one per cycle while the output
// does not stall, then returns the range and all probabilities to their
// reset values in the same cycle as the last byte; adapt_shift keeps its
// value. The last output byte of every item carries last set; an encode item
// may deliver no byte at all. The user must write adapt_shift through
// cfg_wr_en and cfg_wr_data only while the block is idle; the block does not
// enforce it. Zero acts as one and values above eight act as eight.
// ----------------------------------------------------------------------------
module binary_arith_encoder_order0 (
  input  logic                   clk,
  input  logic                   rst,
  // Input item channel.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   op,
  input  logic [7:0]             symbol,
  // Result item channel.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_byte,
  output logic                   last,
  // Configuration register.
  input  logic                   cfg_wr_en,
  input  logic [3:0]             cfg_wr_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_UPD   = 6'b000100,
    S_EMIT  = 6'b001000,
    S_LAST  = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t                               state, state_next;
  bae_pkg::byte_t                       sym, sym_next;
  bae_pkg::ctx_t                        ctx, ctx_next;
  logic [bae_pkg::BIT_IDX_BITS-1:0]     bitcnt, bitcnt_next;
  logic [bae_pkg::FCNT_BITS-1:0]        fcnt, fcnt_next;
  bae_pkg::shift_t                      adapt_shift;
  logic                                 pend_valid, pend_valid_next;
  bae_pkg::byte_t                       pend_byte, pend_byte_next;

  logic                                 load_out;
  bae_pkg::byte_t                       load_byte;
  logic                                 load_last;
  logic                                 out_free;
  logic                                 accept;
  logic                                 bit_val;
  bae_pkg::ctx_t                        ctx_child;

  bae_pkg::prob_ctl_t                   pctl;
  bae_pkg::coder_ctl_t                  cctl;
  bae_pkg::prob_t                       prob;
  bae_pkg::byte_t                       top_byte;
  logic                                 top_match;

  bae_prob_ram u_prob (
    .clk     (clk),
    .rst     (rst),
    .ctl     (pctl),
    .rd_prob (prob)
  );

  bae_range u_range (
    .clk       (clk),
    .rst       (rst),
    .ctl       (cctl),
    .prob      (prob),
    .top_byte  (top_byte),
    .top_match (top_match)
  );

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign bit_val   = sym[bitcnt];
  assign ctx_child = {ctx[bae_pkg::CTX_BITS-2:0], bit_val};

  always_comb begin
    state_next      = state;
    sym_next        = sym;
    ctx_next        = ctx;
    bitcnt_next     = bitcnt;
    fcnt_next       = fcnt;
    pend_valid_next = pend_valid;
    pend_byte_next  = pend_byte;
    load_out        = 1'b0;
    load_byte       = top_byte;
    load_last       = 1'b0;

    pctl.rd_en      = 1'b0;
    pctl.rd_addr    = ctx_child;
    pctl.wr_en      = 1'b0;
    pctl.wr_addr    = ctx;
    pctl.wr_data    = bae_pkg::prob_adapt(prob, bit_val,
                                          bae_pkg::eff_shift(adapt_shift));
    pctl.clear_all  = 1'b0;

    cctl.mul_en     = 1'b0;
    cctl.upd_en     = 1'b0;
    cctl.bit_val    = bit_val;
    cctl.shift_en   = 1'b0;
    cctl.clear      = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == bae_pkg::OP_FLUSH) begin
            fcnt_next  = '0;
            state_next = S_FLUSH;
          end else begin
            // Fetch the root node while the item is taken.
            sym_next     = symbol;
            ctx_next     = bae_pkg::CTX_ROOT;
            bitcnt_next  = bae_pkg::BIT_MSB;
            pctl.rd_en   = 1'b1;
            pctl.rd_addr = bae_pkg::CTX_ROOT;
            state_next   = S_MUL;
          end
        end
      end
      S_MUL: begin
        cctl.mul_en = 1'b1;
        state_next  = S_UPD;
      end
      S_UPD: begin
        // Narrow the range, store the adapted probability and fetch the
        // child node for the next decision.
        cctl.upd_en = 1'b1;
        pctl.wr_en  = 1'b1;
        pctl.rd_en  = 1'b1;
        ctx_next    = ctx_child;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        if (top_match) begin
          // One byte is held back so that the final one can carry last.
          if (!pend_valid) begin
            pend_valid_next = 1'b1;
            pend_byte_next  = top_byte;
            cctl.shift_en   = 1'b1;
          end else if (out_free) begin
            load_out       = 1'b1;
            load_byte      = pend_byte;
            pend_byte_next = top_byte;
            cctl.shift_en  = 1'b1;
          end
        end else if (bitcnt == '0) begin
          state_next = S_LAST;
        end else begin
          cctl.mul_en = 1'b1;
          bitcnt_next = bitcnt - 1'b1;
          state_next  = S_UPD;
        end
      end
      S_LAST: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          load_out        = 1'b1;
          load_byte       = pend_byte;
          load_last       = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          load_out      = 1'b1;
          load_last     = (fcnt == bae_pkg::FLUSH_LAST);
          cctl.shift_en = 1'b1;
          fcnt_next     = fcnt + 1'b1;
          if (fcnt == bae_pkg::FLUSH_LAST) begin
            cctl.clear     = 1'b1;
            pctl.clear_all = 1'b1;
            state_next     = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pend_valid  <= 1'b0;
      adapt_shift <= bae_pkg::SHIFT_RESET;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
      if (cfg_wr_en) begin
        adapt_shift <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    sym       <= sym_next;
    ctx       <= ctx_next;
    bitcnt    <= bitcnt_next;
    fcnt      <= fcnt_next;
    pend_byte <= pend_byte_next;
  end

  // Output register: a stalled result holds up the coder once it has another byte to load.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte <= load_byte;
      last     <= load_last;
    end
  end

endmodule

### rtl/core/bae_checker.sv
// ----------------------------------------------------------------------------
// bae_checker
// Port-level checks of the arithmetic encoder, bound to its top level.
// ----------------------------------------------------------------------------
`include "binary_arith_encoder_order0_assert.svh"

module bae_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       op,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       last
);

  // Every accepted item makes the block busy.
  `BAE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "item accepted while idle did not make the block busy")

  // A stalled result holds its payload.
  `BAE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(last), "stalled result changed")

  // Once idle, any result still waiting is the final byte of its item.
  `BAE_ASSERT_SAME(a_idle_last, !in_stall && out_valid, last, "non-final byte waiting while idle")

  // A flush always produces bytes, so the block is busy right after it is accepted.
  `BAE_ASSERT_NEXT(a_flush_busy, in_valid && !in_stall && op, in_stall, "flush item did not start")

endmodule

bind binary_arith_encoder_order0 bae_checker u_bae_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .op        (op),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .last      (last)
);

### tb/bae_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bae_stream_checker
// Watches both channels and the register port of the arithmetic encoder,
// predicts the compressed bytes of every accepted item and compares them in
// order with the bytes that the block delivers.
// ----------------------------------------------------------------------------
module bae_stream_checker
  import bae_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       op,
  input  logic [7:0] symbol,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       last,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  output int         errors,
  output int         pending
);

  localparam int unsigned PROB_ONE    = 1 << PROB_BITS;
  localparam int          MAX_RESULTS = 64;
  localparam int          MAX_REPORTS = 10;

  typedef struct packed {
    byte_t value;
    logic  last;
  } coded_byte_t;

  prob_t       prob_q [NODES];
  range_t      low_q;
  range_t      high_q;
  shift_t      shift_q;
  byte_t       item_bytes [$];
  coded_byte_t expected_bytes [$];
  int          result_count;

  task automatic clear_model();
    int i;
    for (i = 0; i < NODES; i++) begin
      prob_q[i] = PROB_HALF;
    end
    low_q  = '0;
    high_q = RANGE_ONES;
  endtask

  task automatic emit_byte(input byte_t b);
    if (item_bytes.size() < MAX_RESULTS) begin
      item_bytes.push_back(b);
    end
  endtask

  task automatic code_symbol(input byte_t sym);
    ctx_t        node;
    range_t      span;
    range_t      mid;
    int unsigned p;
    int unsigned sh;
    int          b;
    if (shift_q == '0) begin
      sh = 1;
    end else if (shift_q > SHIFT_MAX) begin
      sh = 32'(SHIFT_MAX);
    end else begin
      sh = 32'(shift_q);
    end
    node = CTX_ROOT;
    for (b = BYTE_BITS - 1; b >= 0; b--) begin
      p    = 32'(prob_q[node]);
      span = high_q - low_q;
      mid  = low_q + (span >> PROB_BITS) * range_t'(p);
      // A one keeps the lower part of the range, a zero the upper part.
      if (sym[b]) begin
        high_q = mid;
        p      = p + ((PROB_ONE - p) >> sh);
      end else begin
        low_q = mid + range_t'(1);
        p     = p - (p >> sh);
      end
      prob_q[node] = prob_t'(p);
      node = {node[CTX_BITS-2:0], sym[b]};
      while (low_q[RANGE_BITS-1 -: BYTE_BITS] == high_q[RANGE_BITS-1 -: BYTE_BITS]) begin
        emit_byte(low_q[RANGE_BITS-1 -: BYTE_BITS]);
        low_q  = low_q << BYTE_BITS;
        high_q = {high_q[RANGE_BITS-BYTE_BITS-1:0], BYTE_ONES};
      end
    end
  endtask

  task automatic predict_item(input logic item_op, input byte_t sym);
    int k;
    item_bytes.delete();
    if (item_op == OP_FLUSH) begin
      for (k = 0; k < FLUSH_BYTES; k++) begin
        emit_byte(low_q[RANGE_BITS-1-BYTE_BITS*k -: BYTE_BITS]);
      end
      clear_model();
    end else begin
      code_symbol(sym);
    end
    for (k = 0; k < item_bytes.size(); k++) begin
      expected_bytes.push_back('{value: item_bytes[k], last: (k == item_bytes.size() - 1)});
    end
  endtask

  task automatic check_result(input byte_t got_value, input logic got_last);
    coded_byte_t want;
    if (expected_bytes.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("[%0t] unexpected result %0d: byte %02h last %0b, nothing expected",
                 $realtime, result_count, got_value, got_last);
      end
    end else begin
      want = expected_bytes.pop_front();
      if (want.value !== got_value || want.last !== got_last) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("[%0t] mismatch on result %0d: expected byte %02h last %0b, got byte %02h last %0b",
                   $realtime, result_count, want.value, want.last, got_value, got_last);
        end
      end
    end
    result_count++;
  endtask

  // The model, the shift and the expected bytes all start from the reset cycles.
  always @(posedge clk) begin
    if (rst) begin
      clear_model();
      shift_q = SHIFT_RESET;
      expected_bytes.delete();
    end else begin
      if (cfg_wr_en) begin
        shift_q = cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        check_result(out_byte, last);
      end
      if (in_valid && !in_stall) begin
        predict_item(op, symbol);
      end
    end
    pending = expected_bytes.size();
  end

endmodule

### tb/tb_binary_arith_encoder_order0.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_arith_encoder_order0
// Stimulus and verdict for the order-0 binary arithmetic encoder.
// ----------------------------------------------------------------------------
// A short directed part codes the extreme bytes, long runs of one byte and
// flushes of a fresh model. Random phases follow, each under its own mix of
// sender gaps and receiver stalls and under several adaptation shifts,
// including zero and the saturating values. The checker beside the block
// predicts every byte; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_binary_arith_encoder_order0;
  import bae_pkg::*;

  // Cycles of quiet after the last expected byte. An encode item that emits
  // nothing still occupies the block through its bit loop.
  localparam int DRAIN_CYCLES   = 40;
  // The long receiver hold-off that fills the block and stalls its input.
  localparam int HOLD_CYCLES    = 400;
  // Cycles without any item moving on either channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 62;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic       op;
  logic [7:0] symbol;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       last;
  logic       cfg_wr_en;
  logic [3:0] cfg_wr_data;

  int    errors;
  int    pending;
  int    send_idle_pct;
  int    recv_idle_pct;
  int    quiet_cycles;
  int    hold_count;
  bit    hold_req;
  bit    hold_done;
  byte_t favorite;

  binary_arith_encoder_order0 dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .symbol      (symbol),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last        (last),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  bae_stream_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .symbol      (symbol),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last        (last),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .errors      (errors),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random, except while a long hold-off is asked
  // for; then it counts the held cycles itself and reports when done.
  initial begin
    out_stall  = 1'b0;
    hold_count = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        hold_count++;
        if (hold_count >= HOLD_CYCLES) begin
          hold_done = 1'b1;
        end
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // The watchdog restarts whenever an item moves on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item, after a random gap, and holds it until it is accepted.
  // While idle the payload carries noise, a flush code among it.
  task automatic send_item(input logic item_op, input byte_t sym);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      op       <= 1'($urandom_range(1));
      symbol   <= 8'($urandom_range(255));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= item_op;
    symbol   <= sym;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Mostly encode items; about half of the bytes repeat a favorite, which
  // drives probabilities toward their ends and gives items with no output.
  task automatic send_random(input int count);
    int    i;
    logic  item_op;
    byte_t sym;
    for (i = 0; i < count; i++) begin
      item_op = ($urandom_range(99) < 4) ? OP_FLUSH : OP_ENCODE;
      if ($urandom_range(63) == 0) begin
        favorite = byte_t'($urandom_range(255));
      end
      sym = $urandom_range(1) ? favorite : byte_t'($urandom_range(255));
      send_item(item_op, sym);
    end
  endtask

  // Lowers valid, then waits until every expected byte has come and the
  // block has had time to finish an item that emits nothing.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_shift(input shift_t value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int    phase;
    int    i;
    shift_t shifts [6];
    rst           = 1'b1;
    in_valid      = 1'b0;
    op            = OP_ENCODE;
    symbol        = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b0;
    favorite      = byte_t'($urandom_range(255));
    shifts[0] = SHIFT_MAX;
    shifts[1] = SHIFT_MIN;
    shifts[2] = '0;
    shifts[3] = '1;
    shifts[4] = shift_t'(9);
    shifts[5] = SHIFT_RESET;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset shift: extreme and patterned bytes, a
    // run of zeros that soon codes without output, and a flush.
    send_item(OP_ENCODE, 8'h00);
    send_item(OP_ENCODE, 8'hFF);
    send_item(OP_ENCODE, 8'h80);
    send_item(OP_ENCODE, 8'h01);
    send_item(OP_ENCODE, 8'h55);
    send_item(OP_ENCODE, 8'hAA);
    for (i = 0; i < 6; i++) begin
      send_item(OP_ENCODE, 8'h00);
    end
    send_item(OP_FLUSH, 8'hFF);
    // A flush of a fresh model gives eight zero bytes.
    send_item(OP_FLUSH, 8'h00);

    // A shift of zero acts as one: the fastest adaptation.
    write_shift('0);
    send_item(OP_ENCODE, 8'h0F);
    send_item(OP_ENCODE, 8'hF0);
    for (i = 0; i < 4; i++) begin
      send_item(OP_ENCODE, 8'hFF);
    end
    send_item(OP_FLUSH, 8'h00);

    // Fifteen saturates to eight: the slowest adaptation.
    write_shift('1);
    for (i = 0; i < 4; i++) begin
      send_item(OP_ENCODE, 8'hFF);
    end
    send_item(OP_FLUSH, 8'hA5);

    // Random phases: none idle, sender idle, receiver stalling, both.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_idle_pct = 57;
        end
        default: begin
          send_idle_pct = 30;
          recv_idle_pct = 30;
        end
      endcase
      write_shift(shifts[(2 * phase) % 6]);
      send_random(PHASE_ITEMS);
      write_shift(($urandom_range(3) == 0) ? shift_t'($urandom_range(15))
                                           : shifts[(2 * phase + 1) % 6]);
      send_random(PHASE_ITEMS);
      if (phase == 0) begin
        // The receiver holds off while the sender keeps offering items,
        // so the block fills up and stalls its input.
        fork
          begin
            hold_req = 1'b1;
            wait (hold_done);
          end
          send_random(40);
        join
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
